/* hdl/dpwe_pkg.sv */
// ----------------------------------------------------------------------------
// DCC packet waveform encoder package
// Shared types, register indexes and reset values for the encoder.
// ----------------------------------------------------------------------------
package dpwe_pkg;

  // Default width of the half period tick counter.
  localparam int unsigned HALF_COUNT_WIDTH = 8;

  // Depth of the queues between the front end, the engine and the outputs.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Frame body length after the preamble: three zero separators and three bytes.
  localparam logic [5:0] FRAME_BODY_LAST = 6'd27;

  // Configuration register reset values.
  localparam logic [7:0] ONE_HALF_RESET  = 8'd58;
  localparam logic [7:0] ZERO_HALF_RESET = 8'd100;
  localparam logic [4:0] PREAMBLE_RESET  = 5'd12;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ONE_HALF  = 2'd0,
    REG_ZERO_HALF = 2'd1,
    REG_PREAMBLE  = 2'd2
  } cfg_reg_e;

  // Live configuration handed to the engine.
  typedef struct packed {
    logic [7:0] one_half_ticks;
    logic [7:0] zero_half_ticks;
    logic [4:0] preamble_length;
  } cfg_t;

  // Classified input item as queued for the engine.
  typedef struct packed {
    logic       is_req;
    logic [7:0] address;
    logic [7:0] data;
    logic [7:0] check;
    logic [7:0] repeats;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic rail;
    logic busy;
    logic accepted;
    logic done;
  } res_t;

endpackage

/* hdl/dpwe_fifo.sv */
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer in flip-flops; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module dpwe_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/dpwe_front.sv */
// ----------------------------------------------------------------------------
// DCC encoder front end
// Takes input beats, classifies them as tick or packet request, prepares the
// check byte and repeat count, and queues them for the engine.
// ----------------------------------------------------------------------------
module dpwe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic            req_type_i,
  input  logic [7:0]      address_i,
  input  logic [7:0]      command_data_i,
  input  logic [7:0]      repeat_count_i,
  input  logic            cmd_pop_i,
  output dpwe_pkg::cmd_t  cmd_o,
  output logic            cmd_empty_o
);

  dpwe_pkg::cmd_t cmd_in;
  logic [$bits(dpwe_pkg::cmd_t)-1:0] cmd_rdata;

  // Classification: a zero repeat count is sent once.
  always_comb begin
    cmd_in.is_req  = req_type_i;
    cmd_in.address = address_i;
    cmd_in.data    = command_data_i;
    cmd_in.check   = address_i ^ command_data_i;
    cmd_in.repeats = (repeat_count_i == 8'd0) ? 8'd1 : repeat_count_i;
  end

  dpwe_fifo #(
    .Width ($bits(dpwe_pkg::cmd_t)),
    .Depth (dpwe_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = dpwe_pkg::cmd_t'(cmd_rdata);

endmodule

/* hdl/dpwe_engine.sv */
// ----------------------------------------------------------------------------
// DCC encoder waveform engine
// Holds the packet and bit timing state and advances it by one queued beat
// per cycle while the result queue has room, with one result beat for each.
// ----------------------------------------------------------------------------
module dpwe_engine #(
  parameter int unsigned HalfCountWidth = dpwe_pkg::HALF_COUNT_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpwe_pkg::cfg_t  cfg_i,
  input  dpwe_pkg::cmd_t  cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output dpwe_pkg::res_t  res_o
);

  // Length arithmetic is wide enough for an 8-bit register and the limit.
  localparam int unsigned LenW = ((HalfCountWidth > 8) ? HalfCountWidth : 8) + 1;
  localparam logic [LenW-1:0] HalfLimit = LenW'(1) << HalfCountWidth;

  logic [7:0]                address_q, address_d;
  logic [7:0]                data_q, data_d;
  logic [7:0]                check_q, check_d;
  logic [7:0]                repeats_q, repeats_d;
  logic [5:0]                bit_idx_q, bit_idx_d;
  logic                      second_half_q, second_half_d;
  logic [HalfCountWidth-1:0] half_cnt_q, half_cnt_d;
  logic                      active_q, active_d;
  logic                      rail_q, rail_d;

  logic                      step;
  logic [5:0]                pre_len;
  logic [5:0]                body_idx;
  logic [7:0]                cur_byte;
  logic [3:0]                byte_pos;
  logic                      fixed_one;
  logic                      cur_bit;
  logic [7:0]                len_raw;
  logic [LenW-1:0]           len_ext;
  logic [HalfCountWidth-1:0] len_cmp;
  logic [HalfCountWidth-1:0] half_cnt_inc;
  logic [7:0]                repeats_dec;
  logic                      accepted, done;

  assign step       = !cmd_empty_i && !res_full_i;
  assign cmd_pop_o  = step;
  assign res_push_o = step;

  // Work out the level of the current frame bit.
  always_comb begin
    pre_len   = {1'b0, cfg_i.preamble_length};
    body_idx  = bit_idx_q - pre_len;
    cur_byte  = address_q;
    byte_pos  = body_idx[3:0];
    fixed_one = 1'b0;
    if (bit_idx_q < pre_len) begin
      fixed_one = 1'b1;
    end else if (body_idx < 6'd9) begin
      cur_byte = address_q;
      byte_pos = body_idx[3:0];
    end else if (body_idx < 6'd18) begin
      cur_byte = data_q;
      byte_pos = 4'(body_idx - 6'd9);
    end else if (body_idx < 6'd27) begin
      cur_byte = check_q;
      byte_pos = 4'(body_idx - 6'd18);
    end else begin
      fixed_one = 1'b1;
    end
    if (fixed_one) begin
      cur_bit = 1'b1;
    end else if (byte_pos == 4'd0) begin
      cur_bit = 1'b0;
    end else begin
      cur_bit = cur_byte[3'(4'd8 - byte_pos)];
    end
  end

  // Half period length, with zero read as one and a cap at the counter range.
  always_comb begin
    len_raw = cur_bit ? cfg_i.one_half_ticks : cfg_i.zero_half_ticks;
    if (len_raw == 8'd0) begin
      len_raw = 8'd1;
    end
    len_ext = LenW'(len_raw);
    if (len_ext > HalfLimit) begin
      len_ext = HalfLimit;
    end
    len_cmp      = len_ext[HalfCountWidth-1:0];
    half_cnt_inc = half_cnt_q + HalfCountWidth'(1);
    repeats_dec  = repeats_q - 8'd1;
  end

  // Next state for one beat.
  always_comb begin
    address_d     = address_q;
    data_d        = data_q;
    check_d       = check_q;
    repeats_d     = repeats_q;
    bit_idx_d     = bit_idx_q;
    second_half_d = second_half_q;
    half_cnt_d    = half_cnt_q;
    active_d      = active_q;
    rail_d        = rail_q;
    accepted      = 1'b0;
    done          = 1'b0;
    if (cmd_i.is_req) begin
      // A request is only taken while idle.
      if (!active_q) begin
        address_d     = cmd_i.address;
        data_d        = cmd_i.data;
        check_d       = cmd_i.check;
        repeats_d     = cmd_i.repeats;
        bit_idx_d     = '0;
        second_half_d = 1'b0;
        half_cnt_d    = '0;
        active_d      = 1'b1;
        accepted      = 1'b1;
      end
    end else if (active_q) begin
      rail_d     = second_half_q;
      half_cnt_d = half_cnt_inc;
      if (half_cnt_inc == len_cmp) begin
        half_cnt_d = '0;
        if (!second_half_q) begin
          second_half_d = 1'b1;
        end else begin
          second_half_d = 1'b0;
          if (bit_idx_q >= pre_len + dpwe_pkg::FRAME_BODY_LAST) begin
            bit_idx_d = '0;
            repeats_d = repeats_dec;
            if (repeats_dec == 8'd0) begin
              active_d = 1'b0;
              done     = 1'b1;
            end
          end else begin
            bit_idx_d = bit_idx_q + 6'd1;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.rail     = rail_d;
    res_o.busy     = active_d;
    res_o.accepted = accepted;
    res_o.done     = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q     <= '0;
      data_q        <= '0;
      check_q       <= '0;
      repeats_q     <= '0;
      bit_idx_q     <= '0;
      second_half_q <= 1'b0;
      half_cnt_q    <= '0;
      active_q      <= 1'b0;
      rail_q        <= 1'b1;
    end else if (step) begin
      address_q     <= address_d;
      data_q        <= data_d;
      check_q       <= check_d;
      repeats_q     <= repeats_d;
      bit_idx_q     <= bit_idx_d;
      second_half_q <= second_half_d;
      half_cnt_q    <= half_cnt_d;
      active_q      <= active_d;
      rail_q        <= rail_d;
    end
  end

endmodule

/* hdl/dcc_packet_waveform_encoder.sv */
// A beat is held in the input queue, then the engine steps it into the result queue.
// Throughput: one beat per cycle while neither queue stalls the engine.
// Both sides are queues of two entries, so either side may stall on its own.
// Reset (asynchronous, active low): queues empty, engine idle with rail_a high,
// registers at 58 and 100 ticks per half and a preamble of 12 one bits.
// ----------------------------------------------------------------------------
// DCC packet waveform encoder
// Generates the baseline command packet waveform on two antiphase rails,
// one result beat for every tick or request beat.
// ----------------------------------------------------------------------------
module dcc_packet_waveform_encoder #(
  parameter int unsigned HalfCountWidth = dpwe_pkg::HALF_COUNT_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port.
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  // Input queue side.
  input  logic       push,
  output logic       full,
  input  logic       req_type_i,
  input  logic [7:0] address_i,
  input  logic [7:0] command_data_i,
  input  logic [7:0] repeat_count_i,
  // Result queue side.
  output logic       empty,
  input  logic       pop,
  output logic       rail_a_o,
  output logic       rail_b_o,
  output logic       busy_res_o,
  output logic       accepted_o,
  output logic       sequence_done_o
);

  dpwe_pkg::cfg_t cfg_q;
  dpwe_pkg::cmd_t cmd;
  dpwe_pkg::res_t res_in;
  dpwe_pkg::res_t res_out;
  logic           cmd_empty;
  logic           cmd_pop;
  logic           res_full;
  logic           res_push;
  logic [$bits(dpwe_pkg::res_t)-1:0] res_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_half_ticks  <= dpwe_pkg::ONE_HALF_RESET;
      cfg_q.zero_half_ticks <= dpwe_pkg::ZERO_HALF_RESET;
      cfg_q.preamble_length <= dpwe_pkg::PREAMBLE_RESET;
    end else if (cfg_we_i) begin
      case (dpwe_pkg::cfg_reg_e'(cfg_addr_i))
        dpwe_pkg::REG_ONE_HALF:  cfg_q.one_half_ticks  <= cfg_wdata_i;
        dpwe_pkg::REG_ZERO_HALF: cfg_q.zero_half_ticks <= cfg_wdata_i;
        dpwe_pkg::REG_PREAMBLE:  cfg_q.preamble_length <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  dpwe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .req_type_i     (req_type_i),
    .address_i      (address_i),
    .command_data_i (command_data_i),
    .repeat_count_i (repeat_count_i),
    .cmd_pop_i      (cmd_pop),
    .cmd_o          (cmd),
    .cmd_empty_o    (cmd_empty)
  );

  dpwe_engine #(
    .HalfCountWidth (HalfCountWidth)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue towards the consumer.
  dpwe_fifo #(
    .Width ($bits(dpwe_pkg::res_t)),
    .Depth (dpwe_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out         = dpwe_pkg::res_t'(res_rdata);
  assign rail_a_o        = res_out.rail;
  assign rail_b_o        = ~res_out.rail;
  assign busy_res_o      = res_out.busy;
  assign accepted_o      = res_out.accepted;
  assign sequence_done_o = res_out.done;

endmodule

/* verif/dpwe_waveform_checker.sv */
// ----------------------------------------------------------------------------
// DCC packet waveform encoder checker
// Watches the register port and both queue sides of the encoder. It keeps its
// own copy of the waveform state, works out the result beat for every input
// beat taken, and compares each popped beat field by field with the oldest one
// still due.
// ----------------------------------------------------------------------------
module dpwe_waveform_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic       req_type_i,
  input  logic [7:0] address_i,
  input  logic [7:0] command_data_i,
  input  logic [7:0] repeat_count_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic       rail_a_i,
  input  logic       rail_b_i,
  input  logic       busy_res_i,
  input  logic       accepted_i,
  input  logic       sequence_done_i,
  output int         fail_count_o,
  output int         beats_due_o,
  output logic       encoder_busy_o,
  output int         beats_checked_o,
  output int         packets_taken_o,
  output int         sequences_ended_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result beat as the encoder presents it.
  typedef struct packed {
    logic rail_a;
    logic rail_b;
    logic busy;
    logic accepted;
    logic done;
  } rail_beat_t;

  // Register copies.
  logic [7:0] one_half_q;
  logic [7:0] zero_half_q;
  logic [4:0] preamble_q;

  // Waveform state.
  logic [7:0] addr_hold;
  logic [7:0] data_hold;
  logic [7:0] check_hold;
  logic [7:0] repeats_left;
  logic [5:0] bit_idx;
  logic       second_half;
  logic [7:0] half_cnt;
  logic       enc_active;
  logic       rail_level;

  rail_beat_t rail_beats_due[$];
  int         faults;
  int         beats_checked;
  int         packets_taken;
  int         sequences_ended;

  assign fail_count_o      = faults;
  assign beats_checked_o   = beats_checked;
  assign packets_taken_o   = packets_taken;
  assign sequences_ended_o = sequences_ended;

  // Prints one line for each fault and counts it.
  task automatic report_fault(input string what);
    faults++;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_fault($sformatf("beat %0d: %s is %b, expected %b", beats_checked, name, got,
                             want));
    end
  endtask

  // Value of a frame bit: preamble ones, then zero and address, zero and data,
  // zero and check byte, all MSB first, and a closing one.
  function automatic logic frame_bit(input logic [5:0] idx);
    int pos;
    pos = int'(idx) - int'(preamble_q);
    if (pos < 0) return 1'b1;
    if (pos == 0 || pos == 9 || pos == 18) return 1'b0;
    if (pos <= 8) return addr_hold[8 - pos];
    if (pos <= 17) return data_hold[17 - pos];
    if (pos <= 26) return check_hold[26 - pos];
    return 1'b1;
  endfunction

  // Advances the waveform by one input beat and returns the beat it causes.
  // With an 8-bit counter a register value can never exceed the counter range,
  // so only a zero half length needs mending.
  function automatic rail_beat_t advance_waveform(input logic is_req, input logic [7:0] addr,
                                                  input logic [7:0] data,
                                                  input logic [7:0] reps);
    rail_beat_t beat;
    logic [7:0] span;
    beat = '0;
    if (is_req) begin
      // A request while a sequence runs is refused and costs no time.
      if (!enc_active) begin
        addr_hold    = addr;
        data_hold    = data;
        check_hold   = addr ^ data;
        repeats_left = (reps == 8'd0) ? 8'd1 : reps;
        bit_idx      = '0;
        second_half  = 1'b0;
        half_cnt     = '0;
        enc_active   = 1'b1;
        beat.accepted = 1'b1;
      end
    end else if (enc_active) begin
      span = frame_bit(bit_idx) ? one_half_q : zero_half_q;
      if (span == 8'd0) span = 8'd1;
      rail_level = second_half;
      half_cnt   = half_cnt + 8'd1;
      if (half_cnt == span) begin
        half_cnt = '0;
        if (!second_half) begin
          second_half = 1'b1;
        end else begin
          second_half = 1'b0;
          if (int'(bit_idx) >= int'(preamble_q) + int'(dpwe_pkg::FRAME_BODY_LAST)) begin
            bit_idx      = '0;
            repeats_left = repeats_left - 8'd1;
            if (repeats_left == 8'd0) begin
              enc_active = 1'b0;
              beat.done  = 1'b1;
            end
          end else begin
            bit_idx = bit_idx + 6'd1;
          end
        end
      end
    end
    beat.rail_a = rail_level;
    beat.rail_b = ~rail_level;
    beat.busy   = enc_active;
    return beat;
  endfunction

  // Register writes, result comparison and prediction, all sampled at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    rail_beat_t got;
    rail_beat_t want;
    if (!rst_ni) begin
      one_half_q      = dpwe_pkg::ONE_HALF_RESET;
      zero_half_q     = dpwe_pkg::ZERO_HALF_RESET;
      preamble_q      = dpwe_pkg::PREAMBLE_RESET;
      addr_hold       = '0;
      data_hold       = '0;
      check_hold      = '0;
      repeats_left    = '0;
      bit_idx         = '0;
      second_half     = 1'b0;
      half_cnt        = '0;
      enc_active      = 1'b0;
      rail_level      = 1'b1;
      faults          = 0;
      beats_checked   = 0;
      packets_taken   = 0;
      sequences_ended = 0;
      rail_beats_due.delete();
      beats_due_o    <= 0;
      encoder_busy_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (dpwe_pkg::cfg_reg_e'(cfg_addr_i))
          dpwe_pkg::REG_ONE_HALF:  one_half_q  = cfg_wdata_i;
          dpwe_pkg::REG_ZERO_HALF: zero_half_q = cfg_wdata_i;
          dpwe_pkg::REG_PREAMBLE:  preamble_q  = cfg_wdata_i[4:0];
          default: ;
        endcase
      end

      // A popped beat is held against the oldest beat still due.
      if (pop_i && !empty_i) begin
        got = '{rail_a_i, rail_b_i, busy_res_i, accepted_i, sequence_done_i};
        if (rail_beats_due.size() == 0) begin
          report_fault("result beat popped with none due");
        end else begin
          want = rail_beats_due.pop_front();
          check_field("rail_a", got.rail_a, want.rail_a);
          check_field("rail_b", got.rail_b, want.rail_b);
          check_field("busy_res", got.busy, want.busy);
          check_field("accepted", got.accepted, want.accepted);
          check_field("sequence_done", got.done, want.done);
          beats_checked++;
        end
      end

      if (push_i && !full_i) begin
        want = advance_waveform(req_type_i, address_i, command_data_i, repeat_count_i);
        if (want.accepted) packets_taken++;
        if (want.done) sequences_ended++;
        rail_beats_due.push_back(want);
      end

      beats_due_o    <= rail_beats_due.size();
      encoder_busy_o <= enc_active;
    end
  end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// DCC packet waveform encoder testbench
// Drives ticks and packet requests into the encoder with random gaps on both
// queue sides, steps through several register settings including the reset
// values and the extremes, and leaves all checking to the waveform checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseBeats = 150;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_addr_i;
  logic [7:0] cfg_wdata_i;
  logic       push;
  logic       full;
  logic       req_type_i;
  logic [7:0] address_i;
  logic [7:0] command_data_i;
  logic [7:0] repeat_count_i;
  logic       empty;
  logic       pop;
  logic       rail_a_o;
  logic       rail_b_o;
  logic       busy_res_o;
  logic       accepted_o;
  logic       sequence_done_o;

  int   fail_count;
  int   beats_due;
  logic encoder_busy;
  int   beats_checked;
  int   packets_taken;
  int   sequences_ended;

  // Burst flags switch off the random gaps for a stretch on each side.
  logic tx_burst;
  logic rx_burst;

  dcc_packet_waveform_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .push            (push),
    .full            (full),
    .req_type_i      (req_type_i),
    .address_i       (address_i),
    .command_data_i  (command_data_i),
    .repeat_count_i  (repeat_count_i),
    .empty           (empty),
    .pop             (pop),
    .rail_a_o        (rail_a_o),
    .rail_b_o        (rail_b_o),
    .busy_res_o      (busy_res_o),
    .accepted_o      (accepted_o),
    .sequence_done_o (sequence_done_o)
  );

  dpwe_waveform_checker waveform_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .push_i            (push),
    .full_i            (full),
    .req_type_i        (req_type_i),
    .address_i         (address_i),
    .command_data_i    (command_data_i),
    .repeat_count_i    (repeat_count_i),
    .empty_i           (empty),
    .pop_i             (pop),
    .rail_a_i          (rail_a_o),
    .rail_b_i          (rail_b_o),
    .busy_res_i        (busy_res_o),
    .accepted_i        (accepted_o),
    .sequence_done_i   (sequence_done_o),
    .fail_count_o      (fail_count),
    .beats_due_o       (beats_due),
    .encoder_busy_o    (encoder_busy),
    .beats_checked_o   (beats_checked),
    .packets_taken_o   (packets_taken),
    .sequences_ended_o (sequences_ended)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #(20ms);
    $display("FAILURE");
    $finish;
  end

  // Result side: a random wait before each beat, then pop until one is taken.
  initial begin
    int gap;
    pop      = 1'b0;
    rx_burst = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // Sends one beat after a random gap. Reports whether a sequence was running
  // before this beat, so the caller knows if a request was refused.
  task automatic send_beat(input logic is_req, input logic [7:0] addr, input logic [7:0] data,
                           input logic [7:0] reps, output logic was_busy);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    req_type_i     <= is_req;
    address_i      <= addr;
    command_data_i <= data;
    repeat_count_i <= reps;
    do @(posedge clk_i); while (full);
    was_busy = encoder_busy;
  endtask

  // Stops pushing and waits until every result beat due has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (beats_due != 0);
  endtask

  // Ticks until the running sequence ends and the queues are empty.
  task automatic finish_sequence();
    logic was_busy;
    wait_drained();
    while (encoder_busy) begin
      send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), was_busy);
    end
    wait_drained();
  endtask

  task automatic write_regs(input logic [7:0] one_v, input logic [7:0] zero_v,
                            input logic [7:0] pre_v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= dpwe_pkg::REG_ONE_HALF;
    cfg_wdata_i <= one_v;
    @(posedge clk_i);
    cfg_addr_i  <= dpwe_pkg::REG_ZERO_HALF;
    cfg_wdata_i <= zero_v;
    @(posedge clk_i);
    cfg_addr_i  <= dpwe_pkg::REG_PREAMBLE;
    cfg_wdata_i <= pre_v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // An idle tick, a request, a second request that must be refused, then the
  // whole sequence played out.
  task automatic run_packet(input logic [7:0] addr, input logic [7:0] data,
                            input logic [7:0] reps);
    logic was_busy;
    send_beat(1'b0, ~addr, ~data, ~reps, was_busy);
    send_beat(1'b1, addr, data, reps, was_busy);
    send_beat(1'b1, data, addr, ~reps, was_busy);
    finish_sequence();
  endtask

  // As above, but only a fixed number of ticks run under the present timing;
  // the queues are then drained and the rest of the sequence runs under the
  // faster timing given.
  task automatic run_cut_packet(input logic [7:0] addr, input logic [7:0] data,
                                input logic [7:0] reps, input int ticks,
                                input logic [7:0] one_v, input logic [7:0] zero_v,
                                input logic [7:0] pre_v);
    logic was_busy;
    send_beat(1'b0, ~addr, ~data, ~reps, was_busy);
    send_beat(1'b1, addr, data, reps, was_busy);
    send_beat(1'b1, data, addr, ~reps, was_busy);
    for (int i = 0; i < ticks; i++) begin
      send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), was_busy);
    end
    wait_drained();
    write_regs(one_v, zero_v, pre_v);
    finish_sequence();
  endtask

  initial begin
    logic       was_busy;
    logic       is_req;
    logic       est_busy;
    logic [7:0] reps;
    int         counted;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = dpwe_pkg::REG_ONE_HALF;
    cfg_wdata_i    = '0;
    push           = 1'b0;
    req_type_i     = 1'b0;
    address_i      = '0;
    command_data_i = '0;
    repeat_count_i = '0;
    tx_burst       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing for the first preamble bit, the rest of the frame faster.
    run_cut_packet(8'hA5, 8'h3C, 8'd1, 116, 8'd2, 8'd1, 8'd12);
    // No preamble, repeat count of zero taken as one.
    write_regs(8'd1, 8'd2, 8'd0);
    run_packet(8'hFF, 8'hFF, 8'd0);
    // Zero half lengths act as one tick; longest preamble.
    write_regs(8'd0, 8'd0, 8'd31);
    run_packet(8'h00, 8'hFF, 8'd2);
    // Longest one bit on the preamble, then the rest at one tick per half.
    write_regs(8'd255, 8'd1, 8'd1);
    run_cut_packet(8'h00, 8'h00, 8'd1, 510, 8'd1, 8'd1, 8'd1);
    // Several repeats on the fastest frame.
    write_regs(8'd1, 8'd1, 8'd0);
    run_packet(8'h5A, 8'hC3, 8'd3);

    // Random phases: short half lengths, so that many packets fit. Stray upper
    // bits on the preamble write must be dropped by the register.
    for (int ph = 0; ph < 4; ph++) begin
      write_regs(8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
                 {3'($urandom_range(0, 7)), 5'($urandom_range(0, 3))});
      est_busy = 1'b0;
      counted  = 0;
      while (counted < PhaseBeats) begin
        // Mostly requests when idle and ticks when busy; the rest is noise.
        if (!est_busy) begin
          is_req = ($urandom_range(0, 6) != 0);
        end else begin
          is_req = ($urandom_range(0, 24) == 0);
        end
        reps = (is_req && !est_busy) ? 8'($urandom_range(0, 2)) : 8'($urandom);
        send_beat(is_req, 8'($urandom), 8'($urandom), reps, was_busy);
        if (!(is_req && was_busy)) counted++;
        est_busy = was_busy || is_req;
      end
      finish_sequence();
    end

    repeat (6) @(posedge clk_i);
    $display("Checked %0d result beats: %0d packets taken, %0d sequences ended.",
             beats_checked, packets_taken, sequences_ended);
    $display("Settings ran from reset timing to zero and full-scale half lengths.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
